// ===== src/crva_pkg.sv =====
// Shared types and constants for the repulsion velocity accumulator.
package crva_pkg;

  localparam int MaxNeighbors = 64;
  localparam int ContactCap = (MaxNeighbors < 127) ? MaxNeighbors : 127;

  localparam logic [15:0] ScaleReset    = 16'd4096;
  localparam logic [15:0] StrengthReset = 16'd2560;

  localparam logic [0:0] RegScale    = 1'b0;
  localparam logic [0:0] RegStrength = 1'b1;

  localparam logic signed [39:0] AccMax = {1'b0, {39{1'b1}}};
  localparam logic signed [39:0] AccMin = {1'b1, {39{1'b0}}};

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP,
    ST_SQRT,
    ST_TEST,
    ST_DIV_FRAC,
    ST_WAIT_FRAC,
    ST_SQ,
    ST_MAG,
    ST_MUL_X,
    ST_DIV_X,
    ST_MUL_Y,
    ST_DIV_Y,
    ST_WAIT_Y,
    ST_ACC,
    ST_OUT
  } state_t;

  // Commands from controller to datapath.
  typedef struct packed {
    logic load;       // capture the request
    logic prep;       // rest length and squared distance
    logic sqrt_start;
    logic div_start;  // starts the shared divider on the selected operands
    logic [1:0] div_sel;  // 0 frac, 1 x, 2 y
    logic sq;
    logic mag;
    logic mul_x;
    logic mul_y;
    logic acc;        // add components, bump contacts
    logic emit;       // load output register, clear state
  } crva_cmd_t;

  typedef struct packed {
    logic present;
    logic last;
    logic overlap;
    logic sqrt_done;
    logic div_done;
  } crva_stat_t;

  localparam logic [1:0] DivFrac = 2'd0;
  localparam logic [1:0] DivX    = 2'd1;
  localparam logic [1:0] DivY    = 2'd2;

endpackage

// ===== src/crva_if.sv =====
// Valid/ready channel carrying one payload.
interface crva_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== src/crva_sqrt.sv =====
// Iterative integer square root, one root bit per cycle.
module crva_sqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [47:0] radicand,
  output logic        done,
  output logic [23:0] root
);
  logic [47:0] rem;
  logic [47:0] acc;
  logic [47:0] bitv;
  logic        busy;
  logic [48:0] trial;

  assign trial = {1'b0, acc} + {1'b0, bitv};
  assign root  = acc[23:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        rem  <= radicand;
        acc  <= '0;
        bitv <= 48'h4000_0000_0000;
      end else if (busy) begin
        if ({1'b0, rem} >= trial) begin
          rem <= rem - trial[47:0];
          acc <= (acc >> 1) + bitv;
        end else begin
          acc <= acc >> 1;
        end
        bitv <= bitv >> 2;
        if (bitv[0]) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

// ===== src/crva_div.sv =====
// Restoring divider, one quotient bit per cycle, 56-bit dividend.
module crva_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [55:0] dividend,
  input  logic [23:0] divisor,
  output logic        done,
  output logic [55:0] quotient
);
  logic [24:0] rem;
  logic [55:0] quo;
  logic [23:0] dvs;
  logic [5:0]  cnt;
  logic        busy;
  logic [25:0] shifted;
  logic [25:0] diff;

  assign shifted  = {rem, quo[55]};
  assign diff     = shifted - {2'b00, dvs};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        rem  <= '0;
        quo  <= dividend;
        dvs  <= divisor;
        cnt  <= 6'd55;
      end else if (busy) begin
        if (!diff[25]) begin
          rem <= diff[24:0];
          quo <= {quo[54:0], 1'b1};
        end else begin
          rem <= shifted[24:0];
          quo <= {quo[54:0], 1'b0};
        end
        cnt <= cnt - 6'd1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

// ===== src/crva_datapath.sv =====
// Datapath: operand registers, root unit, shared divide unit, accumulators, output register.
module crva_datapath (
  input  logic                  clk,
  input  logic                  rst,
  input  crva_pkg::crva_cmd_t   cmd,
  output crva_pkg::crva_stat_t  stat,
  input  logic [15:0]           scale,
  input  logic [15:0]           strength,
  input  logic [23:0]           in_dx,
  input  logic [23:0]           in_dy,
  input  logic [15:0]           in_nbr,
  input  logic [15:0]           in_own,
  input  logic                  in_present,
  input  logic                  in_last,
  output logic [31:0]           out_vx,
  output logic [31:0]           out_vy,
  output logic [6:0]            out_contacts
);
  logic signed [23:0] dx, dy;
  logic [15:0] nbr, own;
  logic        present, last;
  logic [23:0] adx, ady;
  logic [20:0] rest;
  logic [47:0] d2;
  logic [23:0] distance;
  logic [16:0] frac;
  logic [16:0] sq;
  logic [24:0] mag;
  logic [48:0] prod;
  logic [39:0] cx, cy;
  logic signed [39:0] sum_x, sum_y;
  logic [6:0]  contacts;

  logic [23:0] sq_root;
  logic        sq_done;
  logic [55:0] div_q;
  logic        div_done;
  logic [55:0] div_n;
  logic [23:0] div_d;
  logic [32:0] rest_prod;
  logic [46:0] d2x, d2y;
  logic [33:0] frac2;
  logic [32:0] mag_prod;

  assign adx = dx[23] ? 24'(-dx) : 24'(dx);
  assign ady = dy[23] ? 24'(-dy) : 24'(dy);
  assign rest_prod = ({1'b0, nbr} + {1'b0, own}) * scale;
  assign d2x = adx * adx;
  assign d2y = ady * ady;
  assign frac2 = frac * frac;
  assign mag_prod = strength * sq;

  crva_sqrt u_sqrt (
    .clk(clk), .rst(rst), .start(cmd.sqrt_start), .radicand(d2),
    .done(sq_done), .root(sq_root)
  );

  always_comb begin
    case (cmd.div_sel)
      crva_pkg::DivFrac: begin
        div_n = {19'd0, (21'(rest) - 21'(distance)), 16'd0};
        div_d = {3'd0, rest};
      end
      default: begin
        div_n = {7'd0, prod};
        div_d = distance;
      end
    endcase
  end

  crva_div u_div (
    .clk(clk), .rst(rst), .start(cmd.div_start), .dividend(div_n),
    .divisor(div_d), .done(div_done), .quotient(div_q)
  );

  function automatic logic signed [39:0] sat_add(logic signed [39:0] a, logic signed [40:0] d);
    logic signed [41:0] r;
    r = 42'(a) + 42'(d);
    if (r > 42'(crva_pkg::AccMax)) return crva_pkg::AccMax;
    if (r < 42'(crva_pkg::AccMin)) return crva_pkg::AccMin;
    return r[39:0];
  endfunction

  function automatic logic [31:0] sat32(logic signed [39:0] v);
    if (v > 40'sh007FFFFFFF) return 32'h7FFFFFFF;
    if (v < -40'sh0080000000) return 32'h80000000;
    return v[31:0];
  endfunction

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      dx <= in_dx; dy <= in_dy; nbr <= in_nbr; own <= in_own;
      present <= in_present; last <= in_last;
    end
    if (cmd.prep) begin
      rest <= rest_prod[32:12];
      d2 <= {1'b0, d2x} + {1'b0, d2y};
    end
    if (sq_done) distance <= sq_root;
    if (div_done && cmd.div_sel == crva_pkg::DivFrac) frac <= div_q[16:0];
    if (div_done && cmd.div_sel == crva_pkg::DivX) cx <= div_q[39:0];
    if (div_done && cmd.div_sel == crva_pkg::DivY) cy <= div_q[39:0];
    if (cmd.sq) sq <= frac2[32:16];
    if (cmd.mag) mag <= mag_prod[32:8];
    if (cmd.mul_x) prod <= mag * adx;
    if (cmd.mul_y) prod <= mag * ady;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_x <= '0; sum_y <= '0; contacts <= '0;
    end else if (cmd.emit) begin
      out_vx <= sat32(sum_x);
      out_vy <= sat32(sum_y);
      out_contacts <= contacts;
      sum_x <= '0; sum_y <= '0; contacts <= '0;
    end else if (cmd.acc) begin
      sum_x <= sat_add(sum_x, dx[23] ? 41'(cx) : -41'(cx));
      sum_y <= sat_add(sum_y, dy[23] ? 41'(cy) : -41'(cy));
      if (contacts < 7'(crva_pkg::ContactCap)) contacts <= contacts + 7'd1;
    end
  end

  assign stat.present   = present;
  assign stat.last      = last;
  assign stat.overlap   = (distance != '0) && (distance < {3'd0, rest});
  assign stat.sqrt_done = sq_done;
  assign stat.div_done  = div_done;
endmodule

// ===== src/crva_ctrl.sv =====
// Sequencer for one neighbor request and the result handshake.
module crva_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  output crva_pkg::crva_cmd_t   cmd,
  input  crva_pkg::crva_stat_t  stat
);
  crva_pkg::state_t state, state_next;
  logic [1:0] sel, sel_next;
  logic out_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= crva_pkg::ST_IDLE;
      sel <= crva_pkg::DivFrac;
      out_full <= 1'b0;
    end else begin
      state <= state_next;
      sel <= sel_next;
      if (cmd.emit) out_full <= 1'b1;
      else if (out_ready) out_full <= 1'b0;
    end
  end

  assign out_valid = out_full;

  always_comb begin
    state_next = state;
    sel_next = sel;
    cmd = '0;
    cmd.div_sel = sel;
    in_ready = 1'b0;
    case (state)
      crva_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = crva_pkg::ST_PREP;
        end
      end
      crva_pkg::ST_PREP: begin
        if (stat.present) begin
          cmd.prep = 1'b1;
          state_next = crva_pkg::ST_SQRT;
        end else begin
          state_next = stat.last ? crva_pkg::ST_OUT : crva_pkg::ST_IDLE;
        end
      end
      crva_pkg::ST_SQRT: begin
        cmd.sqrt_start = 1'b1;
        state_next = crva_pkg::ST_TEST;
      end
      crva_pkg::ST_TEST: begin
        if (stat.sqrt_done) state_next = crva_pkg::ST_DIV_FRAC;
      end
      crva_pkg::ST_DIV_FRAC: begin
        if (!stat.overlap) begin
          state_next = stat.last ? crva_pkg::ST_OUT : crva_pkg::ST_IDLE;
        end else begin
          cmd.div_sel = crva_pkg::DivFrac;
          sel_next = crva_pkg::DivFrac;
          cmd.div_start = 1'b1;
          state_next = crva_pkg::ST_WAIT_FRAC;
        end
      end
      crva_pkg::ST_WAIT_FRAC: begin
        // frac is registered at the done edge and squared in ST_SQ, the state after
        if (stat.div_done) state_next = crva_pkg::ST_SQ;
      end
      crva_pkg::ST_SQ: begin
        cmd.sq = 1'b1;
        state_next = crva_pkg::ST_MAG;
      end
      crva_pkg::ST_MAG: begin
        cmd.mag = 1'b1;
        state_next = crva_pkg::ST_MUL_X;
      end
      crva_pkg::ST_MUL_X: begin
        cmd.mul_x = 1'b1;
        sel_next = crva_pkg::DivX;
        state_next = crva_pkg::ST_DIV_X;
      end
      crva_pkg::ST_DIV_X: begin
        cmd.div_start = 1'b1;
        state_next = crva_pkg::ST_MUL_Y;
      end
      crva_pkg::ST_MUL_Y: begin
        if (stat.div_done) begin
          cmd.mul_y = 1'b1;
          sel_next = crva_pkg::DivY;
          state_next = crva_pkg::ST_DIV_Y;
        end
      end
      crva_pkg::ST_DIV_Y: begin
        cmd.div_start = 1'b1;
        state_next = crva_pkg::ST_WAIT_Y;
      end
      crva_pkg::ST_WAIT_Y: begin
        if (stat.div_done) state_next = crva_pkg::ST_ACC;
      end
      crva_pkg::ST_ACC: begin
        cmd.acc = 1'b1;
        state_next = stat.last ? crva_pkg::ST_OUT : crva_pkg::ST_IDLE;
      end
      crva_pkg::ST_OUT: begin
        // output register must be free before it is overwritten
        if (!out_full || out_ready) begin
          cmd.emit = 1'b1;
          state_next = crva_pkg::ST_IDLE;
        end
      end
      default: state_next = crva_pkg::ST_IDLE;
    endcase
  end
endmodule

// ===== src/cell_repulsion_velocity_accumulator.sv =====
// Top level of the soft-sphere repulsion velocity accumulator.
// Usage:
//   in  : one neighbor request per item (offsets, radii, present and last flags).
//   out : one result (velocity x/y, contact count) after each request marked last.
//   cfg : write enable, index and 16-bit data; 0 rest length scale, 1 strength.
// Work per request, from acceptance to ready again: an absent neighbor is only
// loaded and checked; a pair that does not overlap also runs the square root;
// an overlapping pair runs the root plus three passes through the one shared
// divider (the fraction and the two components). A request marked last then
// passes through ST_OUT, which loads the result. in.ready is high only while the
// sequencer is idle, so one request is in flight at a time.
// Results sit in an output register; the next request is taken while the
// result waits. A request marked last stalls in the sequencer only if the
// previous result has not yet been taken.
// Reset (rst, synchronous) clears the sums, the contact count, pending
// results and restores the register defaults.
module cell_repulsion_velocity_accumulator (
  input  logic        clk,
  input  logic        rst,
  crva_if.sink        in,
  crva_if.source      out,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  logic [15:0] scale, strength;
  crva_pkg::crva_cmd_t  cmd;
  crva_pkg::crva_stat_t stat;

  always_ff @(posedge clk) begin
    if (rst) begin
      scale <= crva_pkg::ScaleReset;
      strength <= crva_pkg::StrengthReset;
    end else if (cfg_we) begin
      case (cfg_index)
        crva_pkg::RegScale:    scale <= cfg_data;
        crva_pkg::RegStrength: strength <= cfg_data;
        default: ;
      endcase
    end
  end

  crva_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in.valid), .in_ready(in.ready),
    .out_valid(out.valid), .out_ready(out.ready), .cmd(cmd), .stat(stat)
  );

  crva_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat), .scale(scale), .strength(strength),
    .in_dx(in.data.offset_x), .in_dy(in.data.offset_y),
    .in_nbr(in.data.neighbor_radius), .in_own(in.data.own_radius),
    .in_present(in.data.neighbor_present), .in_last(in.data.last_neighbor),
    .out_vx(out.data.velocity_x), .out_vy(out.data.velocity_y),
    .out_contacts(out.data.contact_count)
  );
endmodule
